// ===== hw/rtl/usbc_pkg.sv =====
`default_nettype none

package usbc_pkg;

    localparam int unsigned FuncWidth = 2;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned HaltWidth = 5;
    localparam int unsigned RspWidth = 3;
    localparam int unsigned LenWidth = 2;
    localparam int unsigned DevWidth = 2;

    localparam logic [ByteWidth-1:0] BootIfaceReset = 8'h00;

    typedef enum logic [FuncWidth-1:0] {
        FUNC_SETUP   = 2'd0,
        FUNC_RESET   = 2'd1,
        FUNC_OUTDATA = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef enum logic [RspWidth-1:0] {
        RSP_DATA     = 3'd0,
        RSP_ACK      = 3'd1,
        RSP_STALL    = 3'd2,
        RSP_DELEGATE = 3'd3,
        RSP_NONE     = 3'd4
    } rsp_code_t;

    localparam logic [1:0] TYPE_STANDARD = 2'd0;
    localparam logic [1:0] TYPE_CLASS    = 2'd1;

    localparam logic [4:0] RCPT_DEVICE    = 5'd0;
    localparam logic [4:0] RCPT_INTERFACE = 5'd1;
    localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

    localparam logic [ByteWidth-1:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [ByteWidth-1:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [ByteWidth-1:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [ByteWidth-1:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [ByteWidth-1:0] REQ_SET_CONFIG    = 8'h09;

    localparam logic [ByteWidth-1:0] HID_GET_REPORT    = 8'h01;
    localparam logic [ByteWidth-1:0] HID_GET_PROTOCOL  = 8'h03;
    localparam logic [ByteWidth-1:0] HID_SET_REPORT    = 8'h09;
    localparam logic [ByteWidth-1:0] HID_SET_PROTOCOL  = 8'h0B;

    localparam logic [ByteWidth-1:0] EP_IN1 = 8'h81;
    localparam logic [ByteWidth-1:0] EP_IN2 = 8'h82;
    localparam logic [ByteWidth-1:0] EP_IN3 = 8'h83;
    localparam logic [ByteWidth-1:0] EP_IN4 = 8'h84;
    localparam logic [ByteWidth-1:0] EP_IN5 = 8'h85;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [ByteWidth-1:0] request_type;
        logic [ByteWidth-1:0] request_code;
        logic [ByteWidth-1:0] value_low;
        logic [ByteWidth-1:0] index_low;
        logic [HaltWidth-1:0] endpoint_halt_bits;
        logic [ByteWidth-1:0] out_data_byte;
    } req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/usbc_if.sv =====
`default_nettype none

interface usbc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] request_type;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] index_low;
    logic [4:0] endpoint_halt_bits;
    logic [7:0] out_data_byte;

    modport source (
        output valid, func, request_type, request_code, value_low, index_low,
               endpoint_halt_bits, out_data_byte,
        input  ready
    );
    modport sink (
        input  valid, func, request_type, request_code, value_low, index_low,
               endpoint_halt_bits, out_data_byte,
        output ready
    );
endinterface

interface usbc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] response;
    logic [1:0] data_length;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [1:0] device_state;
    logic       configuration;
    logic       keyboard_protocol;
    logic [7:0] led_level;
    logic       clear_keyboard;

    modport source (
        output valid, response, data_length, data_byte0, data_byte1, device_state,
               configuration, keyboard_protocol, led_level, clear_keyboard,
        input  ready
    );
    modport sink (
        input  valid, response, data_length, data_byte0, data_byte1, device_state,
               configuration, keyboard_protocol, led_level, clear_keyboard,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/usb_control_request_handler.sv =====
// A request beat is held in the input register once accepted, and its result
// is held in the result register until it is taken.
// Throughput: one beat per cycle while results are taken; the input register
// and result register let a new beat enter while a result waits to be taken.
// Reset: rst_n clears the device to the default state, configuration 0, report
// protocol, LED level 0, last request 0 and boot interface BOOT_IFACE_RESET.
`default_nettype none

module usb_control_request_handler #(
    parameter logic [7:0] BOOT_IFACE_RESET = usbc_pkg::BootIfaceReset
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    usbc_req_if.sink        req,
    usbc_rsp_if.source      rsp,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);
    import usbc_pkg::*;

    logic pending;
    logic take;
    req_t beat;

    usbc_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .take    (take),
        .pending (pending),
        .beat    (beat)
    );

    usbc_core #(
        .BOOT_IFACE_RESET (BOOT_IFACE_RESET)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pending     (pending),
        .beat        (beat),
        .take        (take),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/usbc_in_reg.sv =====
`default_nettype none

module usbc_in_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    usbc_req_if.sink          req,
    input  wire logic         take,
    output logic              pending,
    output usbc_pkg::req_t    beat
);
    import usbc_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t beat_reg;
    logic load;

    assign req.ready  = !valid_reg || take;
    assign load       = req.valid && req.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= '{func: req.func, request_type: req.request_type,
                          request_code: req.request_code, value_low: req.value_low,
                          index_low: req.index_low,
                          endpoint_halt_bits: req.endpoint_halt_bits,
                          out_data_byte: req.out_data_byte};
        end
    end

    assign pending = valid_reg;
    assign beat    = beat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/usbc_core.sv =====
`default_nettype none

module usbc_core #(
    parameter logic [7:0] BOOT_IFACE_RESET = usbc_pkg::BootIfaceReset
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic      pending,
    input  wire usbc_pkg::req_t beat,
    output logic           take,
    usbc_rsp_if.source     rsp
);
    import usbc_pkg::*;

    typedef enum logic [DevWidth-1:0] {
        DEV_DEFAULT    = 2'd0,
        DEV_ADDRESSED  = 2'd1,
        DEV_CONFIGURED = 2'd2
    } dev_state_t;

    dev_state_t dev_reg, dev_next;
    logic       config_reg, config_next;
    logic       proto_reg, proto_next;
    logic [7:0] led_reg, led_next;
    logic [7:0] last_reg, last_next;
    logic [7:0] boot_iface_reg;
    logic       out_valid_reg, out_valid_next;

    rsp_code_t  code_next;
    logic [1:0] len_next;
    logic [7:0] b0_next, b1_next;
    logic       clr_next;

    rsp_code_t  code_reg;
    logic [1:0] len_reg;
    logic [7:0] b0_reg, b1_reg;
    logic       clr_reg;

    logic [1:0] req_kind;
    logic [4:0] recipient;
    logic       iface_match;

    assign take           = pending && (!out_valid_reg || rsp.ready);
    assign out_valid_next = take ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    assign req_kind       = beat.request_type[6:5];
    assign recipient      = beat.request_type[4:0];
    assign iface_match    = (beat.index_low == boot_iface_reg);

    always_comb
    begin
        dev_next    = dev_reg;
        config_next = config_reg;
        proto_next  = proto_reg;
        led_next    = led_reg;
        last_next   = last_reg;
        code_next   = RSP_NONE;
        len_next    = 2'd0;
        b0_next     = 8'h00;
        b1_next     = 8'h00;
        clr_next    = 1'b0;
        unique case (func_t'(beat.func))
            FUNC_SETUP:
            begin
                last_next = beat.request_code;
                if (req_kind == TYPE_STANDARD && recipient == RCPT_DEVICE)
                begin
                    unique case (beat.request_code)
                        REQ_GET_STATUS:
                        begin
                            if (dev_reg != DEV_DEFAULT && beat.index_low == 8'h00)
                            begin
                                code_next = RSP_DATA;
                                len_next  = 2'd2;
                            end
                            else
                            begin
                                code_next = RSP_STALL;
                            end
                        end
                        REQ_SET_ADDRESS:
                        begin
                            dev_next = DEV_ADDRESSED;
                        end
                        REQ_GET_DESCRIPTOR:
                        begin
                            code_next = RSP_DELEGATE;
                        end
                        REQ_GET_CONFIG:
                        begin
                            if (dev_reg == DEV_ADDRESSED)
                            begin
                                code_next = RSP_DATA;
                                len_next  = 2'd1;
                            end
                            else if (dev_reg == DEV_CONFIGURED)
                            begin
                                code_next = RSP_DATA;
                                len_next  = 2'd1;
                                b0_next   = {7'b0, config_reg};
                            end
                            else
                            begin
                                code_next = RSP_STALL;
                            end
                        end
                        REQ_SET_CONFIG:
                        begin
                            if (beat.value_low == 8'h00)
                            begin
                                dev_next    = DEV_ADDRESSED;
                                config_next = 1'b0;
                                code_next   = RSP_ACK;
                            end
                            else if (beat.value_low == 8'h01)
                            begin
                                dev_next    = DEV_CONFIGURED;
                                config_next = 1'b1;
                                code_next   = RSP_ACK;
                            end
                            else
                            begin
                                code_next = RSP_STALL;
                            end
                        end
                        default:
                        begin
                            code_next = RSP_STALL;
                        end
                    endcase
                end
                else if (req_kind == TYPE_STANDARD && recipient == RCPT_INTERFACE)
                begin
                    if (beat.request_code == REQ_GET_STATUS && dev_reg == DEV_CONFIGURED)
                    begin
                        code_next = RSP_DATA;
                        len_next  = 2'd2;
                    end
                    else if (beat.request_code == REQ_GET_DESCRIPTOR)
                    begin
                        code_next = RSP_DELEGATE;
                    end
                    else
                    begin
                        code_next = RSP_STALL;
                    end
                end
                else if (req_kind == TYPE_STANDARD && recipient == RCPT_ENDPOINT)
                begin
                    if (beat.request_code == REQ_GET_STATUS && dev_reg == DEV_CONFIGURED)
                    begin
                        code_next = RSP_DATA;
                        len_next  = 2'd2;
                        unique case (beat.index_low)
                            EP_IN1:  b0_next = {7'b0, beat.endpoint_halt_bits[0]};
                            EP_IN2:  b0_next = {7'b0, beat.endpoint_halt_bits[1]};
                            EP_IN3:  b0_next = {7'b0, beat.endpoint_halt_bits[2]};
                            EP_IN4:  b0_next = {7'b0, beat.endpoint_halt_bits[3]};
                            EP_IN5:  b0_next = {7'b0, beat.endpoint_halt_bits[4]};
                            default: b0_next = 8'h00;
                        endcase
                    end
                    else
                    begin
                        code_next = RSP_STALL;
                    end
                end
                else if (req_kind == TYPE_CLASS)
                begin
                    unique case (beat.request_code)
                        HID_GET_REPORT:
                        begin
                            code_next = RSP_DELEGATE;
                        end
                        HID_GET_PROTOCOL:
                        begin
                            if (iface_match)
                            begin
                                code_next = RSP_DATA;
                                len_next  = 2'd1;
                                b0_next   = {7'b0, proto_reg};
                            end
                        end
                        HID_SET_PROTOCOL:
                        begin
                            if (iface_match)
                            begin
                                clr_next = 1'b1;
                                if (beat.value_low == 8'h00)
                                begin
                                    proto_next = 1'b0;
                                    code_next  = RSP_ACK;
                                end
                                else if (beat.value_low == 8'h01)
                                begin
                                    proto_next = 1'b1;
                                    code_next  = RSP_ACK;
                                end
                                else
                                begin
                                    code_next = RSP_STALL;
                                end
                            end
                        end
                        default:
                        begin
                            code_next = RSP_STALL;
                        end
                    endcase
                end
                else
                begin
                    code_next = RSP_STALL;
                end
            end
            FUNC_RESET:
            begin
                dev_next    = DEV_DEFAULT;
                config_next = 1'b0;
            end
            FUNC_OUTDATA:
            begin
                if (last_reg == HID_SET_REPORT)
                begin
                    led_next = beat.out_data_byte;
                end
                code_next = RSP_ACK;
            end
            default:
            begin
                code_next = RSP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg        <= DEV_DEFAULT;
            config_reg     <= 1'b0;
            proto_reg      <= 1'b1;
            led_reg        <= 8'h00;
            last_reg       <= 8'h00;
            boot_iface_reg <= BOOT_IFACE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                boot_iface_reg <= cfg_wr_data;
            end
            if (take)
            begin
                dev_reg    <= dev_next;
                config_reg <= config_next;
                proto_reg  <= proto_next;
                led_reg    <= led_next;
                last_reg   <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_reg <= code_next;
            len_reg  <= len_next;
            b0_reg   <= b0_next;
            b1_reg   <= b1_next;
            clr_reg  <= clr_next;
        end
    end

    // The state fields of a result show the state as it stood after that beat.
    assign rsp.valid             = out_valid_reg;
    assign rsp.response          = code_reg;
    assign rsp.data_length       = len_reg;
    assign rsp.data_byte0        = b0_reg;
    assign rsp.data_byte1        = b1_reg;
    assign rsp.device_state      = dev_reg;
    assign rsp.configuration     = config_reg;
    assign rsp.keyboard_protocol = proto_reg;
    assign rsp.led_level         = led_reg;
    assign rsp.clear_keyboard    = clr_reg;

endmodule

`default_nettype wire
